// ===== design/eipp_pkg.sv =====
// Shared types, record codes and helpers for the Ethernet/IPv4/TCP header parser.
package eipp_pkg;

  localparam int QUEUE_DEPTH_DFLT = 4;

  localparam logic [2:0] KIND_TCP_HDR = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD = 3'd1;
  localparam logic [2:0] KIND_NON_TCP = 3'd2;
  localparam logic [2:0] KIND_BAD_IP  = 3'd3;
  localparam logic [2:0] KIND_BAD_TCP = 3'd4;
  localparam logic [2:0] KIND_TRUNC   = 3'd5;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [6:0]  MIN_HDR    = 7'd20;
  localparam logic [7:0]  PRINT_LO   = 8'h20;
  localparam logic [7:0]  PRINT_HI   = 8'h7E;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  ip_header_bytes;
    logic [5:0]  tcp_header_bytes;
    logic [15:0] payload_bytes;
    logic [7:0]  payload_char;
    logic        last_of_packet;
  } out_item_t;

  // Record request from the parser to the formatter: a snapshot of the captured fields.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  raw_byte;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] ports;
    logic [3:0]  ihl;
    logic [3:0]  tcp_words;
    logic [15:0] ip_total;
    logic        last;
  } cmd_t;

  // IP total length minus both headers, clamped at zero.
  function automatic logic [15:0] calc_payload(input logic [15:0] total,
                                               input logic [3:0]  ihl,
                                               input logic [3:0]  tcp_words);
    logic [6:0] hdrs;
    hdrs = {1'b0, ihl, 2'b00} + {1'b0, tcp_words, 2'b00};
    calc_payload = (total > {9'd0, hdrs}) ? (total - {9'd0, hdrs}) : 16'd0;
  endfunction

endpackage

// ===== design/eth_ipv4_tcp_header_parser.sv =====
// Top level of the Ethernet/IPv4/TCP header parser: parser, record queue, formatter.
//
//  channel  direction  handshake            payload
//  in_      input      in_push / in_full    in_item   (data_byte, last_byte)
//  out_     output     out_empty / out_pop  out_item  (record fields)
//
// One byte is accepted per clock while in_full is low; the parser decides the record in the same cycle.
// A record is written into the queue when its byte is accepted, and moves on into the
// output register when that register is free or is popped in that cycle.
// in_full rises only when the record queue (QUEUE_DEPTH entries) fills because
// out_pop is held low; the output register keeps its item until it is popped.
// Reset is synchronous, active low; it clears the parser state, empties the queue and empties the output register.
module eth_ipv4_tcp_header_parser #(
  parameter int QUEUE_DEPTH = eipp_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  eipp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output eipp_pkg::out_item_t out_item
);
  import eipp_pkg::*;

  logic accept;
  logic f_push;
  cmd_t f_cmd;
  logic q_valid, q_pop;
  cmd_t q_data;

  assign accept = in_push && !in_full;

  eipp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .push    (f_push),
    .cmd     (f_cmd)
  );

  eipp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_cmd),
    .full      (in_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  eipp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== design/eipp_front.sv =====
// Byte parser: tracks frame position, captures header fields, classifies records.
module eipp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  eipp_pkg::in_item_t in_item,
  output logic              push,
  output eipp_pkg::cmd_t    cmd
);
  import eipp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OPTIONS,
    PH_PAYLOAD,
    PH_IGNORE
  } phase_t;

  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  phase_t      phase_r, phase_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [47:0] dst_mac_r, dst_mac_nxt, src_mac_r, src_mac_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [15:0] total_r, total_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_ip_r, src_ip_nxt, dst_ip_r, dst_ip_nxt;
  logic [31:0] port_r, port_nxt;
  logic [15:0] left_r, left_nxt;
  logic [3:0]  tcpw_r, tcpw_nxt;

  logic [6:0]  tcp_start;
  logic [16:0] ts17;
  logic [7:0]  opt_end;
  logic        emit;
  logic [2:0]  kind;
  logic        last_flag;
  logic [7:0]  b;
  logic        lastb;

  always_comb begin
    b     = in_item.data_byte;
    lastb = in_item.last_byte;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    dst_mac_nxt = dst_mac_r;
    src_mac_nxt = src_mac_r;
    etype_nxt   = etype_r;
    ihl_nxt     = ihl_r;
    total_nxt   = total_r;
    proto_nxt   = proto_r;
    src_ip_nxt  = src_ip_r;
    dst_ip_nxt  = dst_ip_r;
    port_nxt    = port_r;
    left_nxt    = left_r;
    tcpw_nxt    = tcpw_r;
    emit        = 1'b0;
    kind        = KIND_TRUNC;
    last_flag   = 1'b1;

    tcp_start = 7'd14 + {1'b0, ihl_r, 2'b00};
    ts17      = {10'd0, tcp_start};
    opt_end   = {1'b0, tcp_start} + {2'b00, tcpw_r, 2'b00} - 8'd1;

    unique case (phase_r)
      PH_HEADER: begin
        if (pos_r < 17'd6) dst_mac_nxt = {dst_mac_r[39:0], b};
        else if (pos_r < 17'd12) src_mac_nxt = {src_mac_r[39:0], b};
        else if (pos_r < 17'd14) etype_nxt = {etype_r[7:0], b};
        else if (pos_r == 17'd14) ihl_nxt = b[3:0];
        else if (pos_r == 17'd16 || pos_r == 17'd17) total_nxt = {total_r[7:0], b};
        else if (pos_r == 17'd23) proto_nxt = b;
        else if (pos_r >= 17'd26 && pos_r < 17'd30) src_ip_nxt = {src_ip_r[23:0], b};
        else if (pos_r >= 17'd30 && pos_r < 17'd34) dst_ip_nxt = {dst_ip_r[23:0], b};
        else if (pos_r >= ts17 && pos_r < ts17 + 17'd4) port_nxt = {port_r[23:0], b};
        else if (pos_r == ts17 + 17'd12) tcpw_nxt = b[7:4];

        if (pos_r == 17'd13 && etype_nxt != ETYPE_IPV4) begin
          phase_nxt = PH_IGNORE;
        end else if (pos_r == 17'd14 && {1'b0, ihl_nxt, 2'b00} < MIN_HDR) begin
          emit = 1'b1; kind = KIND_BAD_IP; last_flag = 1'b1;
          phase_nxt = PH_IGNORE;
        end else if (pos_r == 17'd33 && proto_nxt != PROTO_TCP) begin
          emit = 1'b1; kind = KIND_NON_TCP; last_flag = 1'b1;
          phase_nxt = PH_IGNORE;
        end else if (pos_r >= 17'd34 && pos_r == ts17 + 17'd12) begin
          emit = 1'b1;
          if ({1'b0, tcpw_nxt, 2'b00} < MIN_HDR) begin
            kind = KIND_BAD_TCP; last_flag = 1'b1;
            phase_nxt = PH_IGNORE;
          end else begin
            left_nxt  = calc_payload(total_nxt, ihl_nxt, tcpw_nxt);
            kind      = KIND_TCP_HDR;
            last_flag = (left_nxt == 16'd0) || lastb;
            if (left_nxt == 16'd0) phase_nxt = PH_IGNORE;
            else if (tcpw_nxt > 4'd5) phase_nxt = PH_OPTIONS;
            else phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_OPTIONS: begin
        if (pos_r == {9'd0, opt_end}) phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        left_nxt  = left_r - 16'd1;
        emit      = 1'b1;
        kind      = KIND_PAYLOAD;
        last_flag = (left_nxt == 16'd0) || lastb;
        if (left_nxt == 16'd0) phase_nxt = PH_IGNORE;
      end
      PH_IGNORE: ;
      default: ;
    endcase

    // frame ended while records were still due
    if (lastb && !emit && phase_nxt != PH_IGNORE) begin
      emit = 1'b1; kind = KIND_TRUNC; last_flag = 1'b1;
    end

    cmd.kind      = kind;
    cmd.raw_byte  = b;
    cmd.dst_mac   = dst_mac_nxt;
    cmd.src_mac   = src_mac_nxt;
    cmd.src_ip    = src_ip_nxt;
    cmd.dst_ip    = dst_ip_nxt;
    cmd.ports     = port_nxt;
    cmd.ihl       = ihl_nxt;
    cmd.tcp_words = tcpw_nxt;
    cmd.ip_total  = total_nxt;
    cmd.last      = last_flag;

    if (lastb) begin
      phase_nxt   = PH_HEADER;
      pos_nxt     = '0;
      dst_mac_nxt = '0;
      src_mac_nxt = '0;
      etype_nxt   = '0;
      ihl_nxt     = '0;
      total_nxt   = '0;
      proto_nxt   = '0;
      src_ip_nxt  = '0;
      dst_ip_nxt  = '0;
      port_nxt    = '0;
      left_nxt    = '0;
      tcpw_nxt    = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 17'd1;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      dst_mac_r <= '0;
      src_mac_r <= '0;
      etype_r   <= '0;
      ihl_r     <= '0;
      total_r   <= '0;
      proto_r   <= '0;
      src_ip_r  <= '0;
      dst_ip_r  <= '0;
      port_r    <= '0;
      left_r    <= '0;
      tcpw_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      dst_mac_r <= dst_mac_nxt;
      src_mac_r <= src_mac_nxt;
      etype_r   <= etype_nxt;
      ihl_r     <= ihl_nxt;
      total_r   <= total_nxt;
      proto_r   <= proto_nxt;
      src_ip_r  <= src_ip_nxt;
      dst_ip_r  <= dst_ip_nxt;
      port_r    <= port_nxt;
      left_r    <= left_nxt;
      tcpw_r    <= tcpw_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.last_byte) |=> (pos_r == '0 && phase_r == PH_HEADER))
    else $error("parser state not cleared after frame end");
  a_ignore_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_IGNORE) |-> !push)
    else $error("record produced in ignored part of frame");
`endif

endmodule

// ===== design/eipp_queue.sv =====
// Small record queue between the parser and the output formatter.
module eipp_queue #(
  parameter int DEPTH = eipp_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  eipp_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output eipp_pkg::cmd_t pop_data
);
  import eipp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record pushed into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== design/eipp_back.sv =====
// Output formatter: turns queued records into result items behind an output register.
module eipp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  eipp_pkg::cmd_t    q_data,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output eipp_pkg::out_item_t out_item
);
  import eipp_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      is_pl;

  always_comb begin
    is_pl = (q_data.kind == KIND_TCP_HDR) || (q_data.kind == KIND_PAYLOAD);
    out_item_nxt.record_kind      = q_data.kind;
    out_item_nxt.dst_mac          = q_data.dst_mac;
    out_item_nxt.src_mac          = q_data.src_mac;
    out_item_nxt.src_ip           = q_data.src_ip;
    out_item_nxt.dst_ip           = q_data.dst_ip;
    out_item_nxt.src_port         = q_data.ports[31:16];
    out_item_nxt.dst_port         = q_data.ports[15:0];
    out_item_nxt.ip_header_bytes  = {q_data.ihl, 2'b00};
    out_item_nxt.tcp_header_bytes = {q_data.tcp_words, 2'b00};
    out_item_nxt.payload_bytes    = is_pl ?
      calc_payload(q_data.ip_total, q_data.ihl, q_data.tcp_words) : 16'd0;
    if (q_data.kind != KIND_PAYLOAD) out_item_nxt.payload_char = 8'd0;
    else if (q_data.raw_byte >= PRINT_LO && q_data.raw_byte <= PRINT_HI)
      out_item_nxt.payload_char = q_data.raw_byte;
    else out_item_nxt.payload_char = CHAR_DOT;
    out_item_nxt.last_of_packet   = q_data.last;
  end

  assign q_pop     = q_valid && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (q_pop) out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.record_kind <= KIND_TRUNC))
    else $error("undefined record kind on output");
  a_char_mapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.record_kind == KIND_PAYLOAD) |->
      ((out_item_r.payload_char >= PRINT_LO && out_item_r.payload_char <= PRINT_HI)))
    else $error("payload char not printable");
`endif

endmodule
